>>> sv/rpc_pkg.sv
// shared types and constants of the rst polynomial controller
package rpc_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 16;
	localparam int PROD_W      = SAMPLE_W + COEF_W;
	localparam int PACK_W      = 64;
	localparam int PACKED_TAPS = PACK_W / COEF_W;
	localparam int TAPS_W      = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int FRAC_BITS   = 12;
	// eleven 32-bit products at most, plus headroom for the rounding constant
	localparam int ACC_W       = 36;
	localparam int QUO_W       = ACC_W - FRAC_BITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_F_PACK = 3'd0,
		REG_G_PACK = 3'd1,
		REG_R_PACK = 3'd2,
		REG_F_TAPS = 3'd3,
		REG_G_TAPS = 3'd4,
		REG_R_TAPS = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [PACK_W-1:0] f_pack;
		logic [PACK_W-1:0] g_pack;
		logic [PACK_W-1:0] r_pack;
		logic [TAPS_W-1:0] f_taps;
		logic [TAPS_W-1:0] g_taps;
		logic [TAPS_W-1:0] r_taps;
	} coef_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

endpackage

>>> sv/rpc_if.sv
// handshake channels: sample request, drive result, register write
interface rpc_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [rpc_pkg::SAMPLE_W-1:0]  target_sample;
	logic signed [rpc_pkg::SAMPLE_W-1:0]  measured_sample;

	modport source (output valid, target_sample, measured_sample, input ready);
	modport sink   (input valid, target_sample, measured_sample, output ready);
	modport mon    (input valid, ready, target_sample, measured_sample);
endinterface

interface rpc_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [rpc_pkg::SAMPLE_W-1:0]  drive_value;
	logic                                 saturated;

	modport source (output valid, drive_value, saturated, input ready);
	modport sink   (input valid, drive_value, saturated, output ready);
	modport mon    (input valid, ready, drive_value, saturated);
endinterface

interface rpc_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [rpc_pkg::CFG_IDX_W-1:0]        index;
	logic [rpc_pkg::PACK_W-1:0]           data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
	modport mon    (input valid, ready, index, data);
endinterface

>>> sv/rpc_front.sv
// front end: takes sample requests, shifts histories, forms the R and G partial sum
module rpc_front #(
	parameter int MAX_TAPS = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	rpc_in_if.sink                             sample_ch,
	input  rpc_pkg::coef_t                     coef,
	input  rpc_pkg::queue_stat_t               q_stat,
	output logic                               push,
	output logic signed [rpc_pkg::ACC_W-1:0]   push_data
);

	localparam int LANES = (MAX_TAPS < rpc_pkg::PACKED_TAPS) ? MAX_TAPS : rpc_pkg::PACKED_TAPS;

	logic signed [rpc_pkg::SAMPLE_W-1:0] t_hist_q [LANES-1];
	logic signed [rpc_pkg::SAMPLE_W-1:0] m_hist_q [LANES-1];
	logic signed [rpc_pkg::SAMPLE_W-1:0] t_tap    [LANES];
	logic signed [rpc_pkg::SAMPLE_W-1:0] m_tap    [LANES];
	logic signed [rpc_pkg::COEF_W-1:0]   r_coef   [LANES];
	logic signed [rpc_pkg::COEF_W-1:0]   g_coef   [LANES];
	logic signed [rpc_pkg::PROD_W-1:0]   r_prod_s1 [LANES];
	logic signed [rpc_pkg::PROD_W-1:0]   g_prod_s1 [LANES];
	logic                                vld_s1;
	logic                                advance;
	logic                                accept;

	assign advance         = !vld_s1 || !q_stat.full;
	assign sample_ch.ready = advance;
	assign accept          = sample_ch.valid && advance;
	assign push            = vld_s1 && !q_stat.full;

	// newest sample sits on lane zero, older ones come from the history line
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (i == 0) begin
				t_tap[i] = sample_ch.target_sample;
				m_tap[i] = sample_ch.measured_sample;
			end else begin
				t_tap[i] = t_hist_q[i-1];
				m_tap[i] = m_hist_q[i-1];
			end
			// taps beyond the programmed count read as zero
			r_coef[i] = (rpc_pkg::TAPS_W'(i) < coef.r_taps) ?
				signed'(coef.r_pack[rpc_pkg::COEF_W*i +: rpc_pkg::COEF_W]) : '0;
			g_coef[i] = (rpc_pkg::TAPS_W'(i) < coef.g_taps) ?
				signed'(coef.g_pack[rpc_pkg::COEF_W*i +: rpc_pkg::COEF_W]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < LANES - 1; i++) begin
				t_hist_q[i] <= '0;
				m_hist_q[i] <= '0;
			end
		end else begin
			if (advance) begin
				vld_s1 <= accept;
			end
			if (accept) begin
				for (int i = 0; i < LANES - 1; i++) begin
					t_hist_q[i] <= t_tap[i];
					m_hist_q[i] <= m_tap[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < LANES; i++) begin
				r_prod_s1[i] <= r_coef[i] * t_tap[i];
				g_prod_s1[i] <= g_coef[i] * m_tap[i];
			end
		end
	end

	always_comb begin
		push_data = '0;
		for (int i = 0; i < LANES; i++) begin
			push_data = push_data + rpc_pkg::ACC_W'(r_prod_s1[i])
				- rpc_pkg::ACC_W'(g_prod_s1[i]);
		end
	end

endmodule

>>> sv/rpc_queue.sv
// short queue of partial sums between front and back end
module rpc_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  logic signed [rpc_pkg::ACC_W-1:0]   push_data,
	input  logic                               pop,
	output logic signed [rpc_pkg::ACC_W-1:0]   pop_data,
	output rpc_pkg::queue_stat_t               stat
);

	logic signed [rpc_pkg::ACC_W-1:0] entry_q [rpc_pkg::QUEUE_DEPTH];
	logic [rpc_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [rpc_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [rpc_pkg::QPTR_W:0]         count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (rpc_pkg::QPTR_W + 1)'(rpc_pkg::QUEUE_DEPTH));
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> sv/rpc_back.sv
// back end: closes the F loop on past outputs, rounds, saturates, holds the result
module rpc_back #(
	parameter int MAX_TAPS = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rpc_pkg::coef_t                     coef,
	input  rpc_pkg::queue_stat_t               q_stat,
	input  logic signed [rpc_pkg::ACC_W-1:0]   pop_data,
	output logic                               pop,
	rpc_out_if.source                          drive_ch
);

	localparam int LANES = (MAX_TAPS < rpc_pkg::PACKED_TAPS) ? MAX_TAPS : rpc_pkg::PACKED_TAPS;

	logic signed [rpc_pkg::SAMPLE_W-1:0] u_hist_q [LANES-1];
	logic signed [rpc_pkg::COEF_W-1:0]   f_coef   [LANES-1];
	logic signed [rpc_pkg::PROD_W-1:0]   f_prod   [LANES-1];
	logic signed [rpc_pkg::ACC_W-1:0]    acc;
	logic signed [rpc_pkg::QUO_W-1:0]    quo;
	logic signed [rpc_pkg::SAMPLE_W-1:0] drive_nxt;
	logic                                sat_nxt;
	logic signed [rpc_pkg::SAMPLE_W-1:0] drive_q;
	logic                                sat_q;
	logic                                out_vld_q;

	assign pop = !q_stat.empty && (!out_vld_q || drive_ch.ready);

	// u_hist_q[j] is the output of j+1 requests ago and meets F tap j+1
	always_comb begin
		acc = pop_data;
		for (int j = 0; j < LANES - 1; j++) begin
			f_coef[j] = (rpc_pkg::TAPS_W'(j + 1) < coef.f_taps) ?
				signed'(coef.f_pack[rpc_pkg::COEF_W*(j+1) +: rpc_pkg::COEF_W]) : '0;
			f_prod[j] = f_coef[j] * u_hist_q[j];
			acc = acc - rpc_pkg::ACC_W'(f_prod[j]);
		end
	end

	// round half up, then clip when the quotient leaves the 16-bit range
	always_comb begin
		quo     = rpc_pkg::QUO_W'((acc + rpc_pkg::ROUND_HALF) >>> rpc_pkg::FRAC_BITS);
		sat_nxt = (quo[rpc_pkg::QUO_W-1:rpc_pkg::SAMPLE_W-1] != '0) &&
			(quo[rpc_pkg::QUO_W-1:rpc_pkg::SAMPLE_W-1] != '1);
		if (!sat_nxt) begin
			drive_nxt = quo[rpc_pkg::SAMPLE_W-1:0];
		end else if (quo[rpc_pkg::QUO_W-1]) begin
			drive_nxt = {1'b1, {(rpc_pkg::SAMPLE_W-1){1'b0}}};
		end else begin
			drive_nxt = {1'b0, {(rpc_pkg::SAMPLE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			for (int j = 0; j < LANES - 1; j++) begin
				u_hist_q[j] <= '0;
			end
		end else begin
			if (pop) begin
				out_vld_q   <= 1'b1;
				u_hist_q[0] <= drive_nxt;
				for (int j = 1; j < LANES - 1; j++) begin
					u_hist_q[j] <= u_hist_q[j-1];
				end
			end else if (drive_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			drive_q <= drive_nxt;
			sat_q   <= sat_nxt;
		end
	end

	assign drive_ch.valid       = out_vld_q;
	assign drive_ch.drive_value = drive_q;
	assign drive_ch.saturated   = sat_q;

endmodule

>>> sv/rst_polynomial_controller_top.sv
// top level: register file, front end, partial sum queue and back end
// throughput: one request per cycle sustained while drive results are taken, set by the back end F loop
// a request's partial sum passes the front product registers, the queue and the output register in turn
// the four-entry queue lets the front keep taking requests while a result waits
// reset: histories cleared, coefficient packs zero, f_taps one, g_taps and r_taps zero
// reset needs no clearing pass; requests are taken from the first edge after reset
module rst_polynomial_controller_top #(
	parameter int MAX_TAPS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	rpc_in_if.sink     sample_ch,
	rpc_out_if.source  drive_ch,
	rpc_cfg_if.sink    cfg_ch
);

	rpc_pkg::coef_t                    coef_q;
	rpc_pkg::queue_stat_t              q_stat;
	logic                              push;
	logic                              pop;
	logic signed [rpc_pkg::ACC_W-1:0]  push_data;
	logic signed [rpc_pkg::ACC_W-1:0]  pop_data;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.f_pack <= '0;
			coef_q.g_pack <= '0;
			coef_q.r_pack <= '0;
			coef_q.f_taps <= rpc_pkg::TAPS_W'(1);
			coef_q.g_taps <= '0;
			coef_q.r_taps <= '0;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				rpc_pkg::REG_F_PACK: begin
					coef_q.f_pack <= cfg_ch.data;
				end
				rpc_pkg::REG_G_PACK: begin
					coef_q.g_pack <= cfg_ch.data;
				end
				rpc_pkg::REG_R_PACK: begin
					coef_q.r_pack <= cfg_ch.data;
				end
				rpc_pkg::REG_F_TAPS: begin
					coef_q.f_taps <= cfg_ch.data[rpc_pkg::TAPS_W-1:0];
				end
				rpc_pkg::REG_G_TAPS: begin
					coef_q.g_taps <= cfg_ch.data[rpc_pkg::TAPS_W-1:0];
				end
				rpc_pkg::REG_R_TAPS: begin
					coef_q.r_taps <= cfg_ch.data[rpc_pkg::TAPS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	rpc_front #(
		.MAX_TAPS (MAX_TAPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.coef      (coef_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	rpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	rpc_back #(
		.MAX_TAPS (MAX_TAPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef_q),
		.q_stat   (q_stat),
		.pop_data (pop_data),
		.pop      (pop),
		.drive_ch (drive_ch)
	);

endmodule

>>> sv/rpc_checker.sv
// port-level checks of the controller, bound to the top level
module rpc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_ready,
	input  logic                                drive_valid,
	input  logic                                drive_ready,
	input  logic signed [rpc_pkg::SAMPLE_W-1:0] drive_value,
	input  logic                                saturated,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready
);

	// a result held back by the consumer keeps its value
	a_drive_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && !drive_ready |=>
			drive_valid && $stable(drive_value) && $stable(saturated))
		else $error("drive result changed while stalled");

	// a clipped result sits exactly on one of the range limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && saturated |->
			(drive_value == 16'sh7fff) || (drive_value == 16'sh8000))
		else $error("saturated result off the range limit");

	// the front only stalls when the queue is backed up behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> drive_valid)
		else $error("sample request stalled with no result pending");

	// register writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write refused");

endmodule

bind rst_polynomial_controller_top rpc_checker u_rpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_ready (sample_ch.ready),
	.drive_valid  (drive_ch.valid),
	.drive_ready  (drive_ch.ready),
	.drive_value  (drive_ch.drive_value),
	.saturated    (drive_ch.saturated),
	.cfg_valid    (cfg_ch.valid),
	.cfg_ready    (cfg_ch.ready)
);
